/* hw/rtl/aabb_contact_resolver_core_assert.svh */
// assertion macros for the contact resolver
`ifndef AABB_CONTACT_RESOLVER_CORE_ASSERT_SVH
`define AABB_CONTACT_RESOLVER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ACR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("contact resolver check failed");

// next-cycle implication, checked outside reset
`define ACR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("contact resolver sequence check failed");

`endif

/* hw/rtl/acr_pkg.sv */
// shared constants for the contact resolver
package acr_pkg;

  localparam int STEP_W       = 20;
  localparam int BOUNCE_W     = 16;
  localparam int MASS_W       = 16;
  localparam int DEN_W        = MASS_W + 1;
  localparam int BSUM_W       = BOUNCE_W + 2;
  localparam int FPROD_W      = BSUM_W + STEP_W + 1;
  localparam int F_W          = FPROD_W + 1;
  localparam int FMAG_W       = 38;
  localparam int FSPLIT       = FMAG_W / 2;
  localparam int FACTOR_SHIFT = 23;
  localparam int ROUND_SHIFT  = 24;

  localparam logic [STEP_W-1:0]       STEP_RESET = 20'd15360;
  localparam logic signed [BSUM_W-1:0] BOUNCE_ONE = 18'sd32768;

endpackage

/* hw/rtl/acr_div.sv */
// pipelined two-lane restoring divider, one quotient bit per stage
module acr_div import acr_pkg::*; #(
  parameter int QW    = 32,
  parameter int TAG_W = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic [QW+MASS_W-1:0]    in_num_a,
  input  logic [QW+MASS_W-1:0]    in_num_b,
  input  logic [DEN_W-1:0]        in_den,
  input  logic [TAG_W-1:0]        in_tag,
  output logic                    out_vld,
  output logic [QW-1:0]           out_q_a,
  output logic [QW-1:0]           out_q_b,
  output logic [TAG_W-1:0]        out_tag
);

  localparam int WW = DEN_W + QW;

  logic             vld_r [QW];
  logic [WW-1:0]    wa_r  [QW];
  logic [WW-1:0]    wb_r  [QW];
  logic [DEN_W-1:0] den_r [QW];
  logic [TAG_W-1:0] tag_r [QW];

  function automatic logic [WW-1:0] div_step(input logic [WW-1:0] w,
                                             input logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    logic           ge;
    logic [DEN_W:0] d;
    t  = {w[WW-1:QW], w[QW-1]};
    ge = (t >= {1'b0, den});
    d  = ge ? (t - {1'b0, den}) : t;
    return {d[DEN_W-1:0], w[QW-2:0], ge};
  endfunction

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic             vld_in;
    logic [WW-1:0]    wa_in;
    logic [WW-1:0]    wb_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;

    if (k == 0) begin : g_first
      assign vld_in = in_vld;
      assign wa_in  = {1'b0, in_num_a};
      assign wb_in  = {1'b0, in_num_b};
      assign den_in = in_den;
      assign tag_in = in_tag;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign wa_in  = wa_r[k-1];
      assign wb_in  = wb_r[k-1];
      assign den_in = den_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      wa_r[k]  <= div_step(wa_in, den_in);
      wb_r[k]  <= div_step(wb_in, den_in);
      den_r[k] <= den_in;
      tag_r[k] <= tag_in;
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_q_a = wa_r[QW-1][QW-1:0];
  assign out_q_b = wb_r[QW-1][QW-1:0];
  assign out_tag = tag_r[QW-1];

endmodule

/* hw/rtl/aabb_contact_resolver_core.sv */
// top level of the box pair contact resolver
//
//  channel   ports                       handshake
//  request   start, busy, in_*           taken when start && !busy
//  result    out_valid, out_*            one-cycle strobe, no back-pressure
//  config    cfg_wr_en, cfg_wr_data      written when cfg_wr_en
//
// one request per cycle
// pipe: seven arithmetic stages, the one-bit-per-stage share divider
// (COORD_WIDTH stages) and the output register
// busy stays low; the receiver cannot stall, so nothing holds the pipe
// synchronous reset clears valid bits and loads inverse_step with 60.0
`include "aabb_contact_resolver_core_assert.svh"
module aabb_contact_resolver_core import acr_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_first_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_y,
  input  logic [COORD_WIDTH-2:0]        in_first_width,
  input  logic [COORD_WIDTH-2:0]        in_first_height,
  input  logic [BOUNCE_W-1:0]           in_first_bounce,
  input  logic [MASS_W-1:0]             in_first_inverse_mass,
  input  logic signed [COORD_WIDTH-1:0] in_second_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_y,
  input  logic [COORD_WIDTH-2:0]        in_second_width,
  input  logic [COORD_WIDTH-2:0]        in_second_height,
  input  logic [BOUNCE_W-1:0]           in_second_bounce,
  input  logic [MASS_W-1:0]             in_second_inverse_mass,
  output logic                          out_valid,
  output logic                          out_overlapping,
  output logic signed [COORD_WIDTH-1:0] out_first_move_x,
  output logic signed [COORD_WIDTH-1:0] out_first_move_y,
  output logic signed [COORD_WIDTH-1:0] out_second_move_x,
  output logic signed [COORD_WIDTH-1:0] out_second_move_y,
  input  logic                          cfg_wr_en,
  input  logic [STEP_W-1:0]             cfg_wr_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int EW  = CW + 2;
  localparam int DXW = CW + 3;
  localparam int DW  = CW + 1;
  localparam int LW  = (DW + 1) / 2;
  localparam int HW  = DW - LW;
  localparam int PW  = DW + FMAG_W;
  localparam int PSW = PW + 1;
  localparam int RW  = PSW - ROUND_SHIFT;
  localparam int NW  = CW + MASS_W;
  localparam logic [CW-1:0] NEG_LIM = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] POS_LIM = {1'b0, {(CW-1){1'b1}}};

  typedef struct packed {
    logic          ovl;
    logic          use_y;
    logic          neg;
    logic          am0;
    logic          bm0;
    logic [CW-1:0] total;
  } tag_t;

  logic [STEP_W-1:0] step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_wr_en) begin
      step_r <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // stage 1: overlap test, centre differences, size sums and bounce sum
  logic signed [EW-1:0]  ax_e, ay_e, bx_e, by_e, aw_e, ah_e, bw_e, bh_e;
  logic signed [DXW-1:0] ax3, ay3, bx3, by3, aw3, ah3, bw3, bh3;
  logic                  ovl_nxt;
  logic signed [DXW-1:0] dx_nxt, dy_nxt;

  assign ax_e = EW'(in_first_x);
  assign ay_e = EW'(in_first_y);
  assign bx_e = EW'(in_second_x);
  assign by_e = EW'(in_second_y);
  assign aw_e = $signed({3'b000, in_first_width});
  assign ah_e = $signed({3'b000, in_first_height});
  assign bw_e = $signed({3'b000, in_second_width});
  assign bh_e = $signed({3'b000, in_second_height});
  assign ax3  = DXW'(in_first_x);
  assign ay3  = DXW'(in_first_y);
  assign bx3  = DXW'(in_second_x);
  assign by3  = DXW'(in_second_y);
  assign aw3  = $signed({4'b0000, in_first_width});
  assign ah3  = $signed({4'b0000, in_first_height});
  assign bw3  = $signed({4'b0000, in_second_width});
  assign bh3  = $signed({4'b0000, in_second_height});

  assign ovl_nxt = (ax_e < bx_e + bw_e) && (ax_e + aw_e > bx_e) &&
                   (ay_e < by_e + bh_e) && (ay_e + ah_e > by_e);
  assign dx_nxt  = (ax3 <<< 1) + aw3 - (bx3 <<< 1) - bw3;
  assign dy_nxt  = (ay3 <<< 1) + ah3 - (by3 <<< 1) - bh3;

  logic                     s1_vld_r;
  logic                     s1_ovl_r;
  logic signed [DXW-1:0]    s1_dx_r, s1_dy_r;
  logic [CW-1:0]            s1_sx_r, s1_sy_r;
  logic signed [BSUM_W-1:0] s1_bsum_r;
  logic [MASS_W-1:0]        s1_am_r, s1_bm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_ovl_r  <= ovl_nxt;
    s1_dx_r   <= dx_nxt;
    s1_dy_r   <= dy_nxt;
    s1_sx_r   <= CW'(in_first_width) + CW'(in_second_width);
    s1_sy_r   <= CW'(in_first_height) + CW'(in_second_height);
    s1_bsum_r <= $signed({2'b00, in_first_bounce}) + $signed({2'b00, in_second_bounce})
                 - BOUNCE_ONE;
    s1_am_r   <= in_first_inverse_mass;
    s1_bm_r   <= in_second_inverse_mass;
  end

  // stage 2: depths, axis choice, factor product
  logic signed [DXW-1:0] adx, ady, depx, depy;
  logic                  use_y_nxt;

  assign adx       = s1_dx_r[DXW-1] ? -s1_dx_r : s1_dx_r;
  assign ady       = s1_dy_r[DXW-1] ? -s1_dy_r : s1_dy_r;
  assign depx      = $signed({3'b000, s1_sx_r}) - adx;
  assign depy      = $signed({3'b000, s1_sy_r}) - ady;
  assign use_y_nxt = depx > depy;

  logic                      s2_vld_r, s2_ovl_r, s2_use_y_r, s2_dir_neg_r;
  logic [DW-1:0]             s2_depth_r;
  logic signed [FPROD_W-1:0] s2_fprod_r;
  logic [MASS_W-1:0]         s2_am_r, s2_bm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_ovl_r     <= s1_ovl_r;
    s2_use_y_r   <= use_y_nxt;
    s2_depth_r   <= use_y_nxt ? depy[DW-1:0] : depx[DW-1:0];
    s2_dir_neg_r <= use_y_nxt ? !(s1_dy_r > 0) : !(s1_dx_r > 0);
    s2_fprod_r   <= s1_bsum_r * $signed({1'b0, step_r});
    s2_am_r      <= s1_am_r;
    s2_bm_r      <= s1_bm_r;
  end

  // stage 3: factor sign and magnitude
  logic signed [F_W-1:0] f_val, f_abs;

  assign f_val = F_W'(s2_fprod_r) + (F_W'(1) <<< FACTOR_SHIFT);
  assign f_abs = f_val[F_W-1] ? -f_val : f_val;

  logic              s3_vld_r, s3_ovl_r, s3_use_y_r, s3_neg_r;
  logic [DW-1:0]     s3_depth_r;
  logic [FMAG_W-1:0] s3_fmag_r;
  logic [MASS_W-1:0] s3_am_r, s3_bm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_ovl_r   <= s2_ovl_r;
    s3_use_y_r <= s2_use_y_r;
    s3_neg_r   <= s2_dir_neg_r ^ f_val[F_W-1];
    s3_depth_r <= s2_depth_r;
    s3_fmag_r  <= f_abs[FMAG_W-1:0];
    s3_am_r    <= s2_am_r;
    s3_bm_r    <= s2_bm_r;
  end

  // stage 4: partial products of depth times factor
  logic                      s4_vld_r, s4_ovl_r, s4_use_y_r, s4_neg_r;
  logic [LW+FSPLIT-1:0]      s4_p00_r;
  logic [LW+FMAG_W-FSPLIT-1:0] s4_p01_r;
  logic [HW+FSPLIT-1:0]      s4_p10_r;
  logic [HW+FMAG_W-FSPLIT-1:0] s4_p11_r;
  logic [MASS_W-1:0]         s4_am_r, s4_bm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_ovl_r   <= s3_ovl_r;
    s4_use_y_r <= s3_use_y_r;
    s4_neg_r   <= s3_neg_r;
    s4_p00_r   <= s3_depth_r[LW-1:0] * s3_fmag_r[FSPLIT-1:0];
    s4_p01_r   <= s3_depth_r[LW-1:0] * s3_fmag_r[FMAG_W-1:FSPLIT];
    s4_p10_r   <= s3_depth_r[DW-1:LW] * s3_fmag_r[FSPLIT-1:0];
    s4_p11_r   <= s3_depth_r[DW-1:LW] * s3_fmag_r[FMAG_W-1:FSPLIT];
    s4_am_r    <= s3_am_r;
    s4_bm_r    <= s3_bm_r;
  end

  // stage 5: sum and round
  logic [PSW-1:0] prod_sum;

  assign prod_sum = PSW'(s4_p00_r) + (PSW'(s4_p01_r) << FSPLIT) +
                    (PSW'(s4_p10_r) << LW) + (PSW'(s4_p11_r) << (LW + FSPLIT)) +
                    (PSW'(1) << (ROUND_SHIFT - 1));

  logic              s5_vld_r, s5_ovl_r, s5_use_y_r, s5_neg_r;
  logic [RW-1:0]     s5_raw_r;
  logic [MASS_W-1:0] s5_am_r, s5_bm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_ovl_r   <= s4_ovl_r;
    s5_use_y_r <= s4_use_y_r;
    s5_neg_r   <= s4_neg_r;
    s5_raw_r   <= prod_sum[PSW-1:ROUND_SHIFT];
    s5_am_r    <= s4_am_r;
    s5_bm_r    <= s4_bm_r;
  end

  // stage 6: saturate total push
  logic [CW-1:0] lim;

  assign lim = s5_neg_r ? NEG_LIM : POS_LIM;

  logic              s6_vld_r, s6_ovl_r, s6_use_y_r, s6_neg_r;
  logic [CW-1:0]     s6_total_r;
  logic [MASS_W-1:0] s6_am_r, s6_bm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_ovl_r   <= s5_ovl_r;
    s6_use_y_r <= s5_use_y_r;
    s6_neg_r   <= s5_neg_r;
    s6_total_r <= (s5_raw_r > RW'(lim)) ? lim : s5_raw_r[CW-1:0];
    s6_am_r    <= s5_am_r;
    s6_bm_r    <= s5_bm_r;
  end

  // stage 7: share numerators
  logic [DEN_W-1:0] mass_sum;
  tag_t             tag_nxt;

  assign mass_sum = {1'b0, s6_am_r} + {1'b0, s6_bm_r};

  always_comb begin
    tag_nxt.ovl   = s6_ovl_r;
    tag_nxt.use_y = s6_use_y_r;
    tag_nxt.neg   = s6_neg_r;
    tag_nxt.am0   = (s6_am_r == '0);
    tag_nxt.bm0   = (s6_bm_r == '0);
    tag_nxt.total = s6_total_r;
  end

  logic             s7_vld_r;
  logic [NW-1:0]    s7_num_a_r, s7_num_b_r;
  logic [DEN_W-1:0] s7_den_r;
  tag_t             s7_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s7_num_a_r <= s6_total_r * s6_am_r + NW'(mass_sum[DEN_W-1:1]);
    s7_num_b_r <= s6_total_r * s6_bm_r + NW'(mass_sum[DEN_W-1:1]);
    s7_den_r   <= mass_sum;
    s7_tag_r   <= tag_nxt;
  end

  logic          dv_vld;
  logic [CW-1:0] dv_q_a, dv_q_b;
  tag_t          dv_tag;

  acr_div #(
    .QW    (CW),
    .TAG_W ($bits(tag_t))
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s7_vld_r),
    .in_num_a (s7_num_a_r),
    .in_num_b (s7_num_b_r),
    .in_den   (s7_den_r),
    .in_tag   (s7_tag_r),
    .out_vld  (dv_vld),
    .out_q_a  (dv_q_a),
    .out_q_b  (dv_q_b),
    .out_tag  (dv_tag)
  );

  // output stage: share select, sign and saturation
  function automatic logic [CW-1:0] pack(input logic neg, input logic [CW-1:0] mag);
    logic [CW-1:0] m;
    if (neg) begin
      m = (mag > NEG_LIM) ? NEG_LIM : mag;
      return -m;
    end
    m = (mag > POS_LIM) ? POS_LIM : mag;
    return m;
  endfunction

  logic [CW-1:0] first_mag, second_mag, first_mv, second_mv;

  always_comb begin
    if (dv_tag.am0 && dv_tag.bm0) begin
      first_mag  = '0;
      second_mag = '0;
    end else if (dv_tag.bm0) begin
      first_mag  = dv_tag.total;
      second_mag = '0;
    end else if (dv_tag.am0) begin
      first_mag  = '0;
      second_mag = dv_tag.total;
    end else begin
      first_mag  = dv_q_a;
      second_mag = dv_q_b;
    end
    first_mv  = dv_tag.ovl ? pack(dv_tag.neg, first_mag) : '0;
    second_mv = dv_tag.ovl ? pack(!dv_tag.neg, second_mag) : '0;
  end

  logic          out_valid_r, out_ovl_r;
  logic [CW-1:0] out_fx_r, out_fy_r, out_sx_r, out_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_ovl_r <= dv_tag.ovl;
    out_fx_r  <= dv_tag.use_y ? '0 : first_mv;
    out_fy_r  <= dv_tag.use_y ? first_mv : '0;
    out_sx_r  <= dv_tag.use_y ? '0 : second_mv;
    out_sy_r  <= dv_tag.use_y ? second_mv : '0;
  end

  assign out_valid         = out_valid_r;
  assign out_overlapping   = out_ovl_r;
  assign out_first_move_x  = $signed(out_fx_r);
  assign out_first_move_y  = $signed(out_fy_r);
  assign out_second_move_x = $signed(out_sx_r);
  assign out_second_move_y = $signed(out_sy_r);

  `ACR_ASSERT_NOW(a_no_overlap_no_move, out_valid && !out_overlapping, (out_fx_r == '0) && (out_fy_r == '0) && (out_sx_r == '0) && (out_sy_r == '0))
  `ACR_ASSERT_NOW(a_one_axis, out_valid, ((out_fx_r == '0) || (out_fy_r == '0)) && ((out_sx_r == '0) || (out_sy_r == '0)))
  `ACR_ASSERT_NOW(a_opposite_x, out_valid && (out_fx_r != '0) && (out_sx_r != '0), out_fx_r[CW-1] != out_sx_r[CW-1])
  `ACR_ASSERT_NXT(a_valid_travels, s1_vld_r, s2_vld_r)

endmodule
